### src/ica_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ica_pkg: shared types and constants
// Arctangent table, register indexes and sequencer states for the attitude
// filter.
// ----------------------------------------------------------------------------
package ica_pkg;

   localparam int AtanLen = 24;

   typedef enum logic [1:0] {
      CSR_ALPHA_ROLL  = 2'd0,
      CSR_ALPHA_PITCH = 2'd1,
      CSR_PERIOD      = 2'd2,
      CSR_DEADBAND    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC_INIT,
      ST_CORDIC_RUN,
      ST_CORDIC_DONE,
      ST_FUSE_PRED,
      ST_FUSE_MIX_A,
      ST_FUSE_MIX_B,
      ST_FUSE_DONE,
      ST_YAW,
      ST_OUT
   } state_type;

   // atan(2^-i) * 2^30, truncated.
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h3243F6A8;
         5'd1:  r = 32'h1DAC6705;
         5'd2:  r = 32'h0FADBAFC;
         5'd3:  r = 32'h07F56EA6;
         5'd4:  r = 32'h03FEAB76;
         5'd5:  r = 32'h01FFD55B;
         5'd6:  r = 32'h00FFFAAA;
         5'd7:  r = 32'h007FFF55;
         5'd8:  r = 32'h003FFFEA;
         5'd9:  r = 32'h001FFFFD;
         5'd10: r = 32'h000FFFFF;
         5'd11: r = 32'h0007FFFF;
         5'd12: r = 32'h0003FFFF;
         5'd13: r = 32'h0001FFFF;
         5'd14: r = 32'h0000FFFF;
         5'd15: r = 32'h00007FFF;
         5'd16: r = 32'h00003FFF;
         5'd17: r = 32'h00001FFF;
         5'd18: r = 32'h00000FFF;
         5'd19: r = 32'h000007FF;
         5'd20: r = 32'h000003FF;
         5'd21: r = 32'h000001FF;
         5'd22: r = 32'h000000FF;
         5'd23: r = 32'h0000007F;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   localparam logic signed [31:0] HalfPiQ30 = 32'sd1686629713;
   localparam logic signed [15:0] PiQ13 = 16'sd25736;

endpackage

### src/ica_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ica_cordic: iterative vectoring CORDIC
// Computes atan2(num, den) in Q3.13 radians, one rotation per cycle.
// ----------------------------------------------------------------------------
module ica_cordic #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] num,
   input  logic signed [15:0] den,
   output logic               done,
   output logic signed [15:0] angle
);

   localparam int Steps = (CORDIC_STEPS < ica_pkg::AtanLen) ? CORDIC_STEPS
                                                            : ica_pkg::AtanLen;
   localparam int Tsh = 30 - ANGLE_BITS;
   localparam int ZW = ANGLE_BITS + 4;
   localparam int CW = 28;

   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [4:0]           step_ff, step_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic                 zero_ff, zero_in;

   logic signed [ZW-1:0] a_step;
   logic signed [ZW-1:0] half_pi;
   logic signed [31:0]   tab;
   logic signed [CW-1:0] cx0, cy0, dx, dy;
   logic signed [ZW+1:0] zr;
   logic signed [ZW+1:0] zc;

   always_comb begin
      tab = $signed(ica_pkg::atan_q30(step_ff));
      a_step = ZW'((tab + (32'sd1 <<< (Tsh - 1))) >>> Tsh);
      half_pi = ZW'((ica_pkg::HalfPiQ30 + (32'sd1 <<< (Tsh - 1))) >>> Tsh);
      cx0 = CW'(den) <<< 8;
      cy0 = CW'(num) <<< 8;
      dx = cx_ff >>> step_ff;
      dy = cy_ff >>> step_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         zero_in = (num == 16'sd0) && (den == 16'sd0);
         if (den < 0) begin
            if (num >= 0) begin
               cx_in = cy0;
               cy_in = -cx0;
               z_in = half_pi;
            end else begin
               cx_in = -cy0;
               cy_in = cx0;
               z_in = -half_pi;
            end
         end else begin
            cx_in = cx0;
            cy_in = cy0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (cy_ff > 0) begin
            cx_in = cx_ff + dy;
            cy_in = cy_ff - dx;
            z_in = z_ff + a_step;
         end else begin
            cx_in = cx_ff - dy;
            cy_in = cy_ff + dx;
            z_in = z_ff - a_step;
         end
         step_in = step_ff + 5'd1;
         if (32'(step_ff) == Steps - 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (ANGLE_BITS >= 13) begin
         zr = ((ZW+2)'(z_ff) + ((ZW+2)'(1) <<< ANGLE_BITS) >>> 14) >>> 0;
         zr = (ANGLE_BITS == 13) ? (ZW+2)'(z_ff)
              : ((ZW+2)'(z_ff) + ((ZW+2)'(1) <<< (ANGLE_BITS - 14)))
                >>> (ANGLE_BITS - 13);
      end else begin
         zr = (ZW+2)'(z_ff) <<< (13 - ANGLE_BITS);
      end
      if (zr > (ZW+2)'(ica_pkg::PiQ13)) zc = (ZW+2)'(ica_pkg::PiQ13);
      else if (zr < -(ZW+2)'(ica_pkg::PiQ13)) zc = -(ZW+2)'(ica_pkg::PiQ13);
      else zc = zr;
   end

   assign done = done_ff;
   assign angle = zero_ff ? 16'sd0 : 16'(zc);

endmodule

### src/ica_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ica_mac: shared multiply-accumulate unit
// One 32x18 signed product per enabled cycle, added to a registered accumulator.
// ----------------------------------------------------------------------------
module ica_mac (
   input  logic               clock,
   input  logic               clear,
   input  logic               enable,
   input  logic signed [31:0] op_a,
   input  logic signed [17:0] op_b,
   output logic signed [63:0] acc
);

   logic signed [63:0] acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (clear) acc_in = '0;
      else if (enable) acc_in = acc_ff + 64'(op_a * op_b);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### src/imu_complementary_attitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude: roll/pitch/yaw complementary filter
// Fuses gyro rates with accelerometer tilt angles from one sample per beat.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// req_      in         three gyro rates (Q4.12), three accel axes (counts)
// rsp_      out        roll, pitch (Q3.13 rad), yaw (Q8.23 rad)
// csr_      in         register index and write data
//
// A sample passes, first for roll and then for pitch, through a CORDIC pass
// on the single iterative rotator and a fusion (prediction, two mix steps,
// store), then through a yaw update and the output register. The first
// sample after reset skips fusion and yaw and loads the CORDIC angles.
// req_ready is high only while idle and no result is stalled, so a new
// sample is taken only once the last one is through; a result waits in the
// output register until taken, and the next sample can be accepted in that
// cycle.
// Reset is synchronous and restores the register defaults and the state.
// ----------------------------------------------------------------------------
module imu_complementary_attitude #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_gyro_roll_rate,
   input  logic signed [15:0] req_gyro_pitch_rate,
   input  logic signed [15:0] req_gyro_yaw_rate,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle_out,
   output logic signed [15:0] rsp_pitch_angle_out,
   output logic signed [31:0] rsp_yaw_angle_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   ica_pkg::state_type state_ff, state_in;

   logic [15:0] alpha_roll_ff, alpha_pitch_ff, period_ff;
   logic [19:0] deadband_ff;
   logic signed [15:0] roll_ff, pitch_ff;
   logic signed [31:0] yaw_ff;
   logic               first_ff;
   logic               axis_ff; // 0 = roll pass, 1 = pitch pass

   // Latched sample.
   logic signed [15:0] gx_ff, gy_ff, gz_ff, ax_ff, ay_ff, az_ff;
   logic signed [15:0] acc_cur_ff;

   // Output register.
   logic               out_valid_ff;
   logic signed [15:0] out_roll_ff, out_pitch_ff;
   logic signed [31:0] out_yaw_ff;

   logic               cordic_start, cordic_done;
   logic signed [15:0] cordic_angle;
   logic               mac_clear, mac_en;
   logic signed [31:0] mac_a;
   logic signed [17:0] mac_b;
   logic signed [63:0] mac_acc;
   logic signed [63:0] pred_ff;

   logic               accept;
   logic [15:0]        alpha_cur;
   logic signed [15:0] est_cur;
   logic signed [15:0] rate_cur;
   logic signed [17:0] alpha_s;
   logic signed [17:0] beta_s;
   logic signed [3:0]  pred_hi;
   logic signed [21:0] hi_prod;
   logic signed [33:0] acc_prod;
   logic signed [63:0] mix_r;
   logic signed [15:0] fused;
   logic signed [31:0] inc;
   logic signed [31:0] mag;
   logic signed [33:0] yaw_diff;
   logic signed [31:0] yaw_sat;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ica_pkg::ST_IDLE) && !(out_valid_ff && !rsp_ready);
   assign csr_ready = 1'b1;

   assign alpha_cur = axis_ff ? alpha_pitch_ff : alpha_roll_ff;
   assign est_cur = axis_ff ? pitch_ff : roll_ff;
   assign rate_cur = axis_ff ? gy_ff : gx_ff;

   ica_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start),
      .num(axis_ff ? ax_ff : ay_ff), .den(az_ff),
      .done(cordic_done), .angle(cordic_angle)
   );

   ica_mac u_mac (
      .clock(clock), .clear(mac_clear), .enable(mac_en),
      .op_a(mac_a), .op_b(mac_b), .acc(mac_acc)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ica_pkg::ST_IDLE:        if (accept) state_in = ica_pkg::ST_CORDIC_INIT;
         ica_pkg::ST_CORDIC_INIT: state_in = ica_pkg::ST_CORDIC_RUN;
         ica_pkg::ST_CORDIC_RUN:  if (cordic_done) state_in = ica_pkg::ST_CORDIC_DONE;
         ica_pkg::ST_CORDIC_DONE: state_in = first_ff ? (axis_ff ? ica_pkg::ST_OUT
                                                                 : ica_pkg::ST_CORDIC_INIT)
                                                      : ica_pkg::ST_FUSE_PRED;
         ica_pkg::ST_FUSE_PRED:   state_in = ica_pkg::ST_FUSE_MIX_A;
         ica_pkg::ST_FUSE_MIX_A:  state_in = ica_pkg::ST_FUSE_MIX_B;
         ica_pkg::ST_FUSE_MIX_B:  state_in = ica_pkg::ST_FUSE_DONE;
         ica_pkg::ST_FUSE_DONE:   state_in = axis_ff ? ica_pkg::ST_YAW
                                                     : ica_pkg::ST_CORDIC_INIT;
         ica_pkg::ST_YAW:         state_in = ica_pkg::ST_OUT;
         ica_pkg::ST_OUT:         state_in = ica_pkg::ST_IDLE;
         default:                 state_in = ica_pkg::ST_IDLE;
      endcase
   end

   // Unit controls. The prediction est*2^15 + rate*dt is built in the MAC.
   // For the mix pred*alpha, the low 31 bits of pred go through the MAC as a
   // non-negative operand; the four bits above them are handled beside it.
   always_comb begin
      cordic_start = (state_ff == ica_pkg::ST_CORDIC_INIT);
      mac_clear = 1'b0;
      mac_en = 1'b0;
      mac_a = '0;
      mac_b = '0;
      case (state_ff)
         ica_pkg::ST_CORDIC_DONE: begin
            mac_clear = 1'b1;
         end
         ica_pkg::ST_FUSE_PRED: begin
            mac_en = 1'b1;
            mac_a = 32'(rate_cur);
            mac_b = 18'(period_ff);
         end
         ica_pkg::ST_FUSE_MIX_A: begin
            mac_clear = 1'b1;
         end
         ica_pkg::ST_FUSE_MIX_B: begin
            mac_en = 1'b1;
            mac_a = $signed({1'b0, pred_ff[30:0]});
            mac_b = 18'(alpha_cur);
         end
         default: ;
      endcase
   end

   // The mix result: low product from the MAC, the top bits of pred times
   // alpha, and the accel angle weighted by 65536 - alpha.
   always_comb begin
      alpha_s = $signed({2'b00, alpha_cur});
      beta_s = 18'sd65536 - alpha_s;
      pred_hi = 4'(pred_ff >>> 31);
      hi_prod = 22'(pred_hi) * 22'(alpha_s);
      acc_prod = 34'(acc_cur_ff) * 34'(beta_s);
      mix_r = mac_acc
            + (64'(hi_prod) <<< 31)
            + (64'(acc_prod) <<< 15)
            + 64'sd1073741824;
      mix_r = mix_r >>> 31;
      if (mix_r > 64'(ica_pkg::PiQ13)) fused = ica_pkg::PiQ13;
      else if (mix_r < -64'(ica_pkg::PiQ13)) fused = -ica_pkg::PiQ13;
      else fused = 16'(mix_r);
      inc = 32'((34'(gz_ff) * $signed({18'd0, period_ff}) + 34'sd16) >>> 5);
      mag = (inc < 0) ? -inc : inc;
      yaw_diff = 34'(yaw_ff) - 34'(inc);
      if (yaw_diff > 34'sd2147483647) yaw_sat = 32'sh7FFFFFFF;
      else if (yaw_diff < -34'sd2147483648) yaw_sat = 32'sh80000000;
      else yaw_sat = 32'(yaw_diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ica_pkg::ST_IDLE;
         alpha_roll_ff <= 16'd62259;
         alpha_pitch_ff <= 16'd62259;
         period_ff <= 16'd1311;
         deadband_ff <= 20'd839;
         roll_ff <= '0;
         pitch_ff <= '0;
         yaw_ff <= '0;
         first_ff <= 1'b1;
         axis_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (ica_pkg::csr_index_type'(csr_index))
               ica_pkg::CSR_ALPHA_ROLL:  alpha_roll_ff <= csr_data[15:0];
               ica_pkg::CSR_ALPHA_PITCH: alpha_pitch_ff <= csr_data[15:0];
               ica_pkg::CSR_PERIOD:      period_ff <= csr_data[15:0];
               ica_pkg::CSR_DEADBAND:    deadband_ff <= csr_data[19:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ica_pkg::ST_IDLE: axis_ff <= 1'b0;
            ica_pkg::ST_CORDIC_DONE: begin
               if (first_ff) begin
                  if (axis_ff) pitch_ff <= cordic_angle;
                  else roll_ff <= cordic_angle;
                  axis_ff <= 1'b1;
               end
            end
            ica_pkg::ST_FUSE_DONE: begin
               if (axis_ff) pitch_ff <= fused;
               else roll_ff <= fused;
               axis_ff <= 1'b1;
            end
            ica_pkg::ST_YAW: begin
               if (mag > $signed({12'd0, deadband_ff})) yaw_ff <= yaw_sat;
            end
            ica_pkg::ST_OUT: begin
               first_ff <= 1'b0;
               out_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
      if (accept) begin
         gx_ff <= req_gyro_roll_rate;
         gy_ff <= req_gyro_pitch_rate;
         gz_ff <= req_gyro_yaw_rate;
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
      end
      if (state_ff == ica_pkg::ST_CORDIC_DONE) begin
         acc_cur_ff <= cordic_angle;
         pred_ff <= 64'(est_cur) <<< 15;
      end
      if (state_ff == ica_pkg::ST_FUSE_MIX_A) pred_ff <= pred_ff + mac_acc;
      if (state_ff == ica_pkg::ST_OUT) begin
         out_roll_ff <= roll_ff;
         out_pitch_ff <= pitch_ff;
         out_yaw_ff <= yaw_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_roll_angle_out = out_roll_ff;
   assign rsp_pitch_angle_out = out_pitch_ff;
   assign rsp_yaw_angle_out = out_yaw_ff;

endmodule

### src/ica_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ica_checker: port-level assertions
// Watches the channels of the attitude filter from its ports.
// ----------------------------------------------------------------------------
module ica_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_roll_angle_out,
   input logic signed [15:0] rsp_pitch_angle_out
);

   // A result beat held back keeps its roll payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_roll_angle_out))
      else $error("result payload changed while stalled");

   // Roll and pitch angles stay within plus or minus pi.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle_out <= 16'sd25736) &&
                    (rsp_roll_angle_out >= -16'sd25736) &&
                    (rsp_pitch_angle_out <= 16'sd25736) &&
                    (rsp_pitch_angle_out >= -16'sd25736))
      else $error("angle out of range");

   // A sample is not taken in the cycle right after another one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while busy");

endmodule

bind imu_complementary_attitude ica_checker u_ica_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_roll_angle_out(rsp_roll_angle_out),
   .rsp_pitch_angle_out(rsp_pitch_angle_out)
);

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: attitude filter checker
// Drives IMU samples and register writes into the complementary filter,
// predicts each fused roll/pitch/yaw beat with a bit-exact local model, and
// compares every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int Steps = 16;
   localparam int AngBits = 16;
   localparam longint PiQ13L = 25736;
   localparam int WatchLimit = 20000;

   // One sample beat and one attitude beat.
   typedef struct packed {
      logic signed [15:0] gx, gy, gz, ax, ay, az;
   } imu_sample_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [31:0] yaw;
   } attitude_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_gyro_roll_rate = '0, req_gyro_pitch_rate = '0;
   logic signed [15:0] req_gyro_yaw_rate = '0, req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0, req_accel_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_roll_angle_out, rsp_pitch_angle_out;
   logic signed [31:0] rsp_yaw_angle_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   imu_complementary_attitude uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: registers and filter estimates.
   logic [15:0] p_alpha_roll, p_alpha_pitch, p_period;
   logic [19:0] p_deadband;
   longint roll_est, pitch_est, yaw_acc;
   bit load_pending;

   attitude_type expected_attitudes[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit quiet_mode = 1'b0;   // when set, neither side inserts idle cycles

   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Full-quadrant vectoring CORDIC: atan2(num, den) in Q3.13.
   function automatic longint tilt_angle(longint num, longint den);
      longint cx, cy, z, dx, dy, a, t;
      int tsh;
      cx = den * 256;
      cy = num * 256;
      z = 0;
      tsh = 30 - AngBits;
      if (num == 0 && den == 0) return 0;
      if (den < 0) begin
         t = cx;
         if (num >= 0) begin
            cx = cy; cy = -t; z = rnd_shift(longint'(ica_pkg::HalfPiQ30), tsh);
         end else begin
            cx = -cy; cy = t; z = -rnd_shift(longint'(ica_pkg::HalfPiQ30), tsh);
         end
      end
      for (int i = 0; i < Steps && i < ica_pkg::AtanLen; i++) begin
         dx = asr(cx, i);
         dy = asr(cy, i);
         a = rnd_shift(longint'(ica_pkg::atan_q30(i[4:0])), tsh);
         if (cy > 0) begin
            cx += dy; cy -= dx; z += a;
         end else begin
            cx -= dy; cy += dx; z -= a;
         end
      end
      z = rnd_shift(z, AngBits - 13);
      return clip(z, -PiQ13L, PiQ13L);
   endfunction

   function automatic longint blend_axis(longint est, longint rate, longint acc,
                                         longint alpha);
      longint pred, mix;
      pred = est * 32768 + rate * longint'(p_period);
      mix = pred * alpha + acc * 32768 * (65536 - alpha);
      return clip(rnd_shift(mix, 31), -PiQ13L, PiQ13L);
   endfunction

   // Advance the local filter by one sample and queue the attitude it yields.
   task automatic predict_attitude(imu_sample_type s);
      longint acc_r, acc_p, inc, mag;
      attitude_type e;
      acc_r = tilt_angle(s.ay, s.az);
      acc_p = tilt_angle(s.ax, s.az);
      if (load_pending) begin
         roll_est = acc_r;
         pitch_est = acc_p;
         load_pending = 1'b0;
      end else begin
         roll_est = blend_axis(roll_est, s.gx, acc_r, p_alpha_roll);
         pitch_est = blend_axis(pitch_est, s.gy, acc_p, p_alpha_pitch);
         inc = rnd_shift(longint'(s.gz) * longint'(p_period), 5);
         mag = inc < 0 ? -inc : inc;
         if (mag > longint'(p_deadband))
            yaw_acc = clip(yaw_acc - inc, -64'sd2147483648, 64'sd2147483647);
      end
      e.roll = roll_est[15:0];
      e.pitch = pitch_est[15:0];
      e.yaw = yaw_acc[31:0];
      expected_attitudes.push_back(e);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic random_gap();
      int n;
      if (!quiet_mode && $urandom_range(3) == 0) begin
         n = $urandom_range(1, 10);
         repeat (n) @(posedge clock);
      end
   endtask

   // Send one sample beat and hold it until the block takes it. The block is
   // busy right after a beat, so valid drops after each accepted beat.
   task automatic send_sample(imu_sample_type s);
      random_gap();
      req_valid <= 1'b1;
      req_gyro_roll_rate <= s.gx;
      req_gyro_pitch_rate <= s.gy;
      req_gyro_yaw_rate <= s.gz;
      req_accel_x <= s.ax;
      req_accel_y <= s.ay;
      req_accel_z <= s.az;
      do @(posedge clock); while (!req_ready);
      predict_attitude(s);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait for the result queue to drain; the block has no silent samples.
   task automatic drain();
      while (expected_attitudes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(ica_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ica_pkg::CSR_ALPHA_ROLL:  p_alpha_roll = value[15:0];
         ica_pkg::CSR_ALPHA_PITCH: p_alpha_pitch = value[15:0];
         ica_pkg::CSR_PERIOD:      p_period = value[15:0];
         ica_pkg::CSR_DEADBAND:    p_deadband = value[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] any_word();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly realistic samples: gravity-ish accel with modest rates.
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      if ($urandom_range(4) == 0) begin
         s = {any_word(), any_word(), any_word(), any_word(), any_word(),
              any_word()};
      end else begin
         s.gx = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         s.gy = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         s.gz = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         s.ax = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         s.ay = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
         s.az = $signed(16'($urandom_range(0, 32767))) - 16'sd8192;
      end
      return s;
   endfunction

   // Corner samples: zero accel, negative z only, full-scale fields.
   task automatic test_directed_corners();
      imu_sample_type c[$];
      c.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096});
      c.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
      c.push_back('{16'sd100, -16'sd100, 16'sd0, 16'sd0, 16'sd0, -16'sd4096});
      c.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    16'sh7FFF});
      c.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    16'sh8000});
      c.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                    16'sh8000});
      c.push_back('{16'sd5, -16'sd5, 16'sd1, 16'sd300, -16'sd300, 16'sd0});
      c.push_back('{16'sd0, 16'sd0, -16'sd1, -16'sd300, 16'sd300, -16'sd1});
      c.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                    16'shAAAA});
      c.push_back('{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                    16'sh5555});
      foreach (c[i]) send_sample(c[i]);
      drain();
   endtask

   // Drive yaw into both saturation limits with a long dt and no deadband.
   // Each full-scale sample moves yaw by about 2^26, so 40 reach the top
   // limit and 80 more cross all the way to the bottom one.
   task automatic test_yaw_saturation();
      write_register(ica_pkg::CSR_PERIOD, 32'hFFFF_FFFF);
      write_register(ica_pkg::CSR_DEADBAND, 32'h0);
      for (int i = 0; i < 40; i++)
         send_sample('{16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd4096});
      for (int i = 0; i < 80; i++)
         send_sample('{16'sd0, 16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd4096});
      drain();
   endtask

   // Random samples under a sequence of register settings, extremes included.
   task automatic test_random_settings(int count);
      logic [31:0] cfg[4][$];
      cfg[0] = '{32'h0, 32'hFFFF, 32'd62259, 32'd32768};
      cfg[1] = '{32'hFFFF, 32'h0, 32'd62259, 32'd1};
      cfg[2] = '{32'h0, 32'hFFFF, 32'd1311, 32'h1_0005};
      cfg[3] = '{32'hFFFFF, 32'h0, 32'd839, 32'hFFFFF};
      for (int phase = 0; phase < 4; phase++) begin
         write_register(ica_pkg::CSR_ALPHA_ROLL, cfg[0][phase]);
         write_register(ica_pkg::CSR_ALPHA_PITCH, cfg[1][phase]);
         write_register(ica_pkg::CSR_PERIOD, cfg[2][phase]);
         write_register(ica_pkg::CSR_DEADBAND, cfg[3][phase]);
         for (int i = 0; i < count; i++) begin
            send_sample(random_sample());
            // Halfway through each phase, hold off until every pending result is back.
            if (i == count / 2) drain();
         end
         drain();
      end
   endtask

   // Result checker with random back-pressure.
   always @(posedge clock) begin
      attitude_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_attitudes.size() == 0) begin
               report_mismatch("unexpected beat", rsp_roll_angle_out, 0);
            end else begin
               e = expected_attitudes.pop_front();
               if (rsp_roll_angle_out !== e.roll)
                  report_mismatch("roll", rsp_roll_angle_out, e.roll);
               if (rsp_pitch_angle_out !== e.pitch)
                  report_mismatch("pitch", rsp_pitch_angle_out, e.pitch);
               if (rsp_yaw_angle_out !== e.yaw)
                  report_mismatch("yaw", rsp_yaw_angle_out, e.yaw);
            end
         end
         rsp_ready <= quiet_mode ? 1'b1 : ($urandom_range(3) != 0);
      end
   end

   // Watchdog: cycles with no beat accepted on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      p_alpha_roll = 16'd62259;
      p_alpha_pitch = 16'd62259;
      p_period = 16'd1311;
      p_deadband = 20'd839;
      roll_est = 0;
      pitch_est = 0;
      yaw_acc = 0;
      load_pending = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_yaw_saturation();
      test_random_settings(150);
      quiet_mode = 1'b1;
      test_random_settings(20);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_attitudes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
